FILE: hdl/slra_pkg.sv
// ----------------------------------------------------------------------------
// slra_pkg
// Shared types, constants and the sRGB linearization table for the
// luminance / ring average unit.
// ----------------------------------------------------------------------------
package slra_pkg;

	localparam int COORD_W = 12;
	localparam int CH_W    = 8;
	localparam int LIN_W   = 17;   // Q1.16, 0..65536
	localparam int PROD_W  = 33;
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 25;
	localparam int MAX_DIM = 4096;

	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Q0.16 luminance weights, they sum to 65536
	localparam logic [15:0] COEF_B = 16'd4732;
	localparam logic [15:0] COEF_G = 16'd46871;
	localparam logic [15:0] COEF_R = 16'd13933;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BOX_LEFT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_TOP     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_RIGHT   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_BOTTOM  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MARGIN_COLS = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MARGIN_ROWS = 3'd5;

	typedef struct packed {
		logic [COORD_W-1:0] box_left;
		logic [COORD_W-1:0] box_top;
		logic [COORD_W-1:0] box_right;
		logic [COORD_W-1:0] box_bottom;
		logic [COORD_W-1:0] margin_cols;
		logic [COORD_W-1:0] margin_rows;
	} slra_cfg_t;

	// one classified pixel between front and back
	typedef struct packed {
		logic [CH_W-1:0] luma;
		logic            in_ring;
		logic            frame_end;
	} slra_item_t;

	typedef logic [255:0][LIN_W-1:0] lin_tab_t;

	// curve constants, evaluated at elaboration only
	localparam logic [127:0] LOW_NUM      = 128'd6553600;
	localparam logic [127:0] LOW_RND      = 128'd164730;
	localparam logic [127:0] LOW_DEN      = 128'd329460;
	localparam logic [127:0] CURVE_DEN_SQ = 128'd72374450625;  // 269025^2

	// Linear segment for codes 0..10, else floor(t^0.4) in Q16 found by
	// bisection on r^5 * b^2 <= a^2 * 2^80, then scaled by t^2 and rounded.
	function automatic lin_tab_t build_lin();
		lin_tab_t     t;
		logic [127:0] a;
		logic [127:0] lo;
		logic [127:0] hi;
		logic [127:0] mid;
		logic [127:0] lhs;
		logic [127:0] rhs;
		for (int i = 0; i < 256; i++) begin
			if (i <= 10) begin
				t[i] = LIN_W'((128'(i) * LOW_NUM + LOW_RND) / LOW_DEN);
			end else begin
				a  = 128'(1000 * i + 14025);
				lo = 128'd0;
				hi = 128'd65536;
				while (lo < hi) begin
					mid = (lo + hi + 128'd1) >> 1;
					lhs = mid * mid * mid * mid * mid * CURVE_DEN_SQ;
					rhs = (a * a) << 80;
					if (lhs <= rhs) lo = mid;
					else hi = mid - 128'd1;
				end
				t[i] = LIN_W'((a * a * lo + (CURVE_DEN_SQ >> 1)) / CURVE_DEN_SQ);
			end
		end
		return t;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin();

endpackage

FILE: hdl/slra_front.sv
// ----------------------------------------------------------------------------
// slra_front
// Three-stage pixel pipeline: table linearization, weighting, sum and
// 8-bit scaling; ring membership is decided on entry and carried along.
// ----------------------------------------------------------------------------
module slra_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [slra_pkg::CH_W-1:0]    blue,
	input  logic [slra_pkg::CH_W-1:0]    green,
	input  logic [slra_pkg::CH_W-1:0]    red,
	input  logic [slra_pkg::COORD_W-1:0] col,
	input  logic [slra_pkg::COORD_W-1:0] row,
	input  logic                         frame_end,
	input  slra_pkg::slra_cfg_t          cfg,
	output logic                         push,
	output slra_pkg::slra_item_t         item,
	output logic [1:0]                   inflight
);
	import slra_pkg::*;

	localparam int C_W = COORD_W + 1;

	logic [C_W-1:0] col_x, row_x;
	logic           outer, inner, ring_s0;

	logic             v_s1, v_s2, v_s3;
	logic [LIN_W-1:0] lin_b_s1, lin_g_s1, lin_r_s1;
	logic             ring_s1, ring_s2, ring_s3;
	logic             fend_s1, fend_s2, fend_s3;
	logic [PROD_W-1:0] pb_s2, pg_s2, pr_s2;
	logic [PROD_W:0]   sum_s3;

	logic [41:0] scaled;
	logic [9:0]  y_full;

	assign col_x = {1'b0, col};
	assign row_x = {1'b0, row};

	always_comb begin
		outer = (col_x + C_W'(cfg.margin_cols) >= C_W'(cfg.box_left))
			&& (col_x < C_W'(cfg.box_right) + C_W'(cfg.margin_cols))
			&& (row_x + C_W'(cfg.margin_rows) >= C_W'(cfg.box_top))
			&& (row_x < C_W'(cfg.box_bottom) + C_W'(cfg.margin_rows))
			&& (32'(col) < 32'(MAX_DIM)) && (32'(row) < 32'(MAX_DIM));
		inner = (col > cfg.box_left) && (col < cfg.box_right)
			&& (row > cfg.box_top) && (row < cfg.box_bottom);
		ring_s0 = outer && !inner;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		lin_b_s1 <= LIN_TAB[blue];
		lin_g_s1 <= LIN_TAB[green];
		lin_r_s1 <= LIN_TAB[red];
		ring_s1  <= ring_s0;
		fend_s1  <= frame_end;

		pb_s2   <= PROD_W'(lin_b_s1) * PROD_W'(COEF_B);
		pg_s2   <= PROD_W'(lin_g_s1) * PROD_W'(COEF_G);
		pr_s2   <= PROD_W'(lin_r_s1) * PROD_W'(COEF_R);
		ring_s2 <= ring_s1;
		fend_s2 <= fend_s1;

		sum_s3  <= (PROD_W+1)'(pb_s2) + (PROD_W+1)'(pg_s2) + (PROD_W+1)'(pr_s2);
		ring_s3 <= ring_s2;
		fend_s3 <= fend_s2;
	end

	// S*255 + 2^31, keep bits above 32, saturate
	assign scaled = (42'(sum_s3) << 8) - 42'(sum_s3) + 42'h0_8000_0000;
	assign y_full = scaled[41:32];

	assign push           = v_s3;
	assign item.luma      = (y_full > 10'd255) ? 8'hFF : y_full[7:0];
	assign item.in_ring   = ring_s3;
	assign item.frame_end = fend_s3;
	assign inflight       = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);

endmodule

FILE: hdl/slra_queue.sv
// ----------------------------------------------------------------------------
// slra_queue
// Small FIFO with a registered head entry between front and back.
// ----------------------------------------------------------------------------
module slra_queue #(
	parameter int DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  slra_pkg::slra_item_t            item_in,
	input  logic                            pop,
	output logic                            head_valid,
	output slra_pkg::slra_item_t            head,
	output logic [$clog2(DEPTH+2)-1:0]      level
);
	import slra_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 2);
	localparam int MEM_W = $clog2(DEPTH + 1);

	slra_item_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [MEM_W-1:0] mem_cnt_q;
	logic             head_valid_q;
	slra_item_t       head_q;

	logic head_take, mem_rd, mem_wr, bypass;

	assign head_take = !head_valid_q || pop;
	assign mem_rd    = head_take && (mem_cnt_q != '0);
	assign bypass    = head_take && (mem_cnt_q == '0) && push;
	assign mem_wr    = push && !bypass;

	always_ff @(posedge clk) begin
		if (mem_wr) mem[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk) begin
		if (mem_rd) head_q <= mem[rd_ptr_q];
		else if (bypass) head_q <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			mem_cnt_q    <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (mem_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (mem_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			mem_cnt_q <= mem_cnt_q + MEM_W'(mem_wr) - MEM_W'(mem_rd);
			if (head_take) head_valid_q <= mem_rd || bypass;
		end
	end

	assign head_valid = head_valid_q;
	assign head       = head_q;
	assign level      = LVL_W'(mem_cnt_q) + LVL_W'(head_valid_q);

endmodule

FILE: hdl/slra_div.sv
// ----------------------------------------------------------------------------
// slra_div
// Restoring divider, one quotient bit per cycle, ring_sum / ring_count.
// ----------------------------------------------------------------------------
module slra_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [slra_pkg::SUM_W-1:0] dividend,
	input  logic [slra_pkg::CNT_W-1:0] divisor,
	output logic                       busy,
	output logic [slra_pkg::SUM_W-1:0] quotient
);
	import slra_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic           fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(SUM_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/slra_back.sv
// ----------------------------------------------------------------------------
// slra_back
// Ring accumulation, frame-end average through the divider, and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module slra_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  slra_pkg::slra_item_t      head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [slra_pkg::CH_W-1:0] luma,
	output logic [slra_pkg::CH_W-1:0] ring_average,
	output logic                      ring_empty,
	output logic                      frame_done
);
	import slra_pkg::*;

	typedef enum logic {
		ST_RUN,
		ST_DIVIDE
	} state_t;

	state_t           state_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [CH_W-1:0]  out_luma_q, out_avg_q, held_luma_q;
	logic             out_empty_q, out_last_q;

	logic             out_free, take, div_start, div_busy, emit;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_next, quotient;
	logic [CNT_W-1:0] cnt_next;
	logic [CH_W-1:0]  avg_clamped;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == ST_RUN) && head_valid && out_free;

	// count stops at its ceiling and then nothing more is added
	assign take     = head.in_ring && (count_q != COUNT_MAX);
	assign sum_add  = {1'b0, sum_q} + (SUM_W+1)'(head.luma);
	assign sum_next = !take ? sum_q : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);
	assign cnt_next = take ? count_q + 1'b1 : count_q;

	assign div_start   = pop && head.frame_end && (cnt_next != '0);
	assign avg_clamped = (quotient[SUM_W-1:CH_W] != '0) ? {CH_W{1'b1}} : quotient[CH_W-1:0];

	// result register loads: a pixel that needs no divide, or the divide is done
	assign emit = (pop && !div_start) || ((state_q == ST_DIVIDE) && !div_busy && out_free);

	slra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (cnt_next),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_luma_q  <= '0;
			out_avg_q   <= '0;
			held_luma_q <= '0;
			out_empty_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (head.frame_end) begin
							sum_q   <= '0;
							count_q <= '0;
							if (cnt_next == '0) begin
								out_luma_q  <= head.luma;
								out_avg_q   <= '0;
								out_empty_q <= 1'b1;
								out_last_q  <= 1'b1;
							end else begin
								held_luma_q <= head.luma;
								state_q     <= ST_DIVIDE;
							end
						end else begin
							sum_q       <= sum_next;
							count_q     <= cnt_next;
							out_luma_q  <= head.luma;
							out_avg_q   <= '0;
							out_empty_q <= 1'b0;
							out_last_q  <= 1'b0;
						end
					end
				end
				ST_DIVIDE: begin
					if (!div_busy && out_free) begin
						out_luma_q  <= held_luma_q;
						out_avg_q   <= avg_clamped;
						out_empty_q <= 1'b0;
						out_last_q  <= 1'b1;
						state_q     <= ST_RUN;
					end
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign luma         = out_luma_q;
	assign ring_average = out_avg_q;
	assign ring_empty   = out_empty_q;
	assign frame_done   = out_last_q;

endmodule

FILE: hdl/srgb_luminance_ring_average_unit.sv
// Path: front stages s1..s3, queue head register, result register; a frame-end pixel
// whose ring holds at least one pixel also runs the 32-step quotient loop in slra_div.
// Throughput: one pixel per cycle when not back-pressured; the quotient loop holds
// the back at each frame end, which the queue and the input tready absorb.
// Reset: arst_n clears the box registers, accumulators, queue and result valid.
// ----------------------------------------------------------------------------
// srgb_luminance_ring_average_unit
// Per-pixel BT.709 relative luminance of an sRGB stream, with the mean
// luminance of the ring around a text box reported on the frame's last pixel.
// ----------------------------------------------------------------------------
module srgb_luminance_ring_average_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input pixels
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [47:0]                         s_tdata,  // blue, green, red, col, row
	input  logic                                s_tlast,  // frame_end
	// results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,  // luma, ring_average
	output logic [0:0]                          m_tuser,  // ring_empty
	output logic                                m_tlast,  // frame_done
	// configuration
	input  logic                                cfg_we,
	input  logic [slra_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [slra_pkg::COORD_W-1:0]        cfg_data
);
	import slra_pkg::*;

	localparam int LVL_W = $clog2(QUEUE_DEPTH + 2);

	slra_cfg_t  cfg_q;
	slra_item_t front_item, q_head;
	logic       front_push, q_head_valid, back_pop, s_xfer;
	logic [1:0] inflight;
	logic [LVL_W-1:0] q_level;
	logic [CH_W-1:0]  out_luma, out_avg;
	logic             out_empty;

	// Register file: writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_LEFT:    cfg_q.box_left    <= cfg_data;
				REG_BOX_TOP:     cfg_q.box_top     <= cfg_data;
				REG_BOX_RIGHT:   cfg_q.box_right   <= cfg_data;
				REG_BOX_BOTTOM:  cfg_q.box_bottom  <= cfg_data;
				REG_MARGIN_COLS: cfg_q.margin_cols <= cfg_data;
				REG_MARGIN_ROWS: cfg_q.margin_rows <= cfg_data;
				default: ;
			endcase
		end
	end

	// Credit check: the front pipeline never stalls, so a pixel is taken
	// only while the queue has room for it plus everything still in flight.
	assign s_tready = (32'(q_level) + 32'(inflight)) < 32'(QUEUE_DEPTH);
	assign s_xfer   = s_tvalid && s_tready;

	// Front: linearize, weight, scale; classify ring membership.
	slra_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_xfer),
		.blue      (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.red       (s_tdata[23:16]),
		.col       (s_tdata[35:24]),
		.row       (s_tdata[47:36]),
		.frame_end (s_tlast),
		.cfg       (cfg_q),
		.push      (front_push),
		.item      (front_item),
		.inflight  (inflight)
	);

	// Decoupling queue, lets the back sit in the divider for a frame end.
	slra_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_push),
		.item_in    (front_item),
		.pop        (back_pop),
		.head_valid (q_head_valid),
		.head       (q_head),
		.level      (q_level)
	);

	// Back: accumulate ring pixels, average on frame end, drive results.
	slra_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop          (back_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.luma         (out_luma),
		.ring_average (out_avg),
		.ring_empty   (out_empty),
		.frame_done   (m_tlast)
	);

	assign m_tdata = {out_avg, out_luma};
	assign m_tuser = out_empty;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for srgb_luminance_ring_average_unit: a directed table
// of corner pixels and box settings, then random frames against an in-bench
// luminance / ring-average predictor, under three source/sink pacing phases
// and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slra_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int SETTLE_CYCLES   = 45;    // covers the pipe and a frame-end divide, with slack
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int MAX_REPORTS     = 10;
	localparam int ITEMS_PER_PHASE = 600;
	localparam int CURVE_B         = 269025;

	// indexes past the register list, writes there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// box settings used by the directed table
	localparam logic [2:0] KEEP_BOX     = 3'd0;
	localparam logic [2:0] BOX_SMALL    = 3'd1;
	localparam logic [2:0] BOX_FULL_MAX = 3'd2;
	localparam logic [2:0] BOX_FRAME    = 3'd3;
	localparam logic [2:0] BOX_INVERTED = 3'd4;

	typedef struct packed {
		logic [CH_W-1:0]    blue;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    red;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] ring_average;
		logic       ring_empty;
		logic       frame_done;
	} result_t;

	typedef struct packed {
		logic [2:0] box_sel;
		pixel_t     px;
		logic       typed;   // row carries a hand-written expectation
		result_t    want;
	} dir_row_t;

	localparam result_t NO_WANT = '0;

	// ------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata   = '0;   // blue, green, red, col, row
	logic                 s_tlast   = 1'b0;  // frame_end
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;          // luma, ring_average
	logic [0:0]           m_tuser;          // ring_empty
	logic                 m_tlast;          // frame_done
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	srgb_luminance_ring_average_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// predictor state: own copy of the box registers and ring accumulators
	// ------------------------------------------------------------------
	logic [LIN_W-1:0] srgb_lin [256];
	slra_cfg_t        box         = '0;
	logic [SUM_W-1:0] ring_total  = '0;
	logic [CNT_W-1:0] ring_pixels = '0;

	result_t pending_results [$];

	int src_idle    = 0;    // percent of cycles the source holds back
	int sink_idle   = 0;    // percent of cycles the sink drops tready
	bit hold_req    = 1'b0; // asks the sink process for one long hold-off
	int idle_cycles = 0;

	// run statistics
	int n_pixels    = 0;
	int n_frames    = 0;
	int n_empty     = 0;
	int n_ring_px   = 0;
	int n_holds     = 0;
	int n_checked   = 0;
	int n_errors    = 0;

	// true when r (Q16) is not above t^0.4, t = a / CURVE_B
	function automatic bit root_ok(logic [127:0] r, logic [127:0] a, logic [127:0] b_sq);
		return (r * r * r * r * r * b_sq) <= ((a * a) << 80);
	endfunction

	// Linear segment up to code 10, power segment above. The Q16 root grows
	// with the code, so it is found by stepping up from the previous one.
	task automatic build_srgb_lin();
		logic [127:0] a;
		logic [127:0] r;
		logic [127:0] b_sq;
		b_sq = 128'(CURVE_B) * 128'(CURVE_B);
		r    = '0;
		for (int i = 0; i < 256; i++) begin
			if (i <= 10) begin
				srgb_lin[i] = LIN_W'((128'(i) * 128'd6553600 + 128'd164730) / 128'd329460);
			end else begin
				a = 128'(1000 * i + 14025);
				while (r < 128'd65536 && root_ok(r + 128'd1, a, b_sq))
					r = r + 128'd1;
				srgb_lin[i] = LIN_W'((a * a * r + (b_sq >> 1)) / b_sq);
			end
		end
	endtask

	function automatic logic [7:0] luma_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		logic [63:0] wsum;
		logic [63:0] y;
		wsum = 64'(COEF_B) * 64'(srgb_lin[b]) + 64'(COEF_G) * 64'(srgb_lin[g])
			+ 64'(COEF_R) * 64'(srgb_lin[r]);
		y = (wsum * 64'd255 + 64'h8000_0000) >> 32;
		return (y > 64'd255) ? 8'd255 : y[7:0];
	endfunction

	// inside the grown box, but not strictly inside the box itself
	function automatic logic in_ring(logic [COORD_W-1:0] c, logic [COORD_W-1:0] rw);
		logic outer;
		logic inner;
		outer = (13'(c) + 13'(box.margin_cols) >= 13'(box.box_left))
			&& (13'(c) < 13'(box.box_right) + 13'(box.margin_cols))
			&& (13'(rw) + 13'(box.margin_rows) >= 13'(box.box_top))
			&& (13'(rw) < 13'(box.box_bottom) + 13'(box.margin_rows));
		inner = (c > box.box_left) && (c < box.box_right)
			&& (rw > box.box_top) && (rw < box.box_bottom);
		return outer && !inner;
	endfunction

	// result of one pixel; advances the ring accumulators
	function automatic result_t predict_pixel(pixel_t p);
		result_t       res;
		logic [32:0]   grown;
		logic [31:0]   quot;
		res              = '0;
		res.luma         = luma_of(p.blue, p.green, p.red);
		res.frame_done   = p.frame_end;
		if (in_ring(p.col, p.row) && ring_pixels != COUNT_MAX) begin
			grown       = 33'(ring_total) + 33'(res.luma);
			ring_total  = (grown > 33'(SUM_MAX)) ? SUM_MAX : grown[31:0];
			ring_pixels = ring_pixels + 1'b1;
			n_ring_px++;
		end
		if (p.frame_end) begin
			if (ring_pixels == '0) begin
				res.ring_empty = 1'b1;
				n_empty++;
			end else begin
				quot             = ring_total / 32'(ring_pixels);
				res.ring_average = (quot > 32'd255) ? 8'd255 : quot[7:0];
			end
			ring_total  = '0;
			ring_pixels = '0;
			n_frames++;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// source side
	// ------------------------------------------------------------------
	// called and returns at a falling edge; leaves tvalid up
	task automatic send_pixel(pixel_t p, logic typed, result_t want);
		result_t pred;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.row, p.col, p.red, p.green, p.blue};
		s_tlast  <= p.frame_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = predict_pixel(p);
		pending_results.push_back(typed ? want : pred);
		n_pixels++;
		@(negedge clk);
	endtask

	// source pauses until every result is back and the divider is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// registers only change with the unit idle
	task automatic program_box(slra_cfg_t c, logic poke_spare);
		settle();
		write_reg(REG_BOX_LEFT,    c.box_left);
		write_reg(REG_BOX_TOP,     c.box_top);
		write_reg(REG_BOX_RIGHT,   c.box_right);
		write_reg(REG_BOX_BOTTOM,  c.box_bottom);
		write_reg(REG_MARGIN_COLS, c.margin_cols);
		write_reg(REG_MARGIN_ROWS, c.margin_rows);
		if (poke_spare) begin
			write_reg(REG_SPARE_A, '1);
			write_reg(REG_SPARE_B, '0);
		end
		cfg_we <= 1'b0;
		box    = c;
		@(negedge clk);
	endtask

	function automatic logic [7:0] random_channel();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 8'd255 : 8'd0;
		return 8'($urandom);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(int v);
		if (v < 0) return '0;
		if (v > 4095) return '1;
		return COORD_W'(v);
	endfunction

	// mostly coordinates around the current box, some anywhere
	function automatic pixel_t random_pixel(logic last);
		pixel_t p;
		int     c_lo;
		int     c_hi;
		int     r_lo;
		int     r_hi;
		p.blue      = random_channel();
		p.green     = random_channel();
		p.red       = random_channel();
		p.frame_end = last;
		if ($urandom_range(3) == 0) begin
			p.col = COORD_W'($urandom);
			p.row = COORD_W'($urandom);
		end else begin
			c_lo  = int'(box.box_left) - int'(box.margin_cols) - 3;
			c_hi  = int'(box.box_right) + int'(box.margin_cols) + 3;
			r_lo  = int'(box.box_top) - int'(box.margin_rows) - 3;
			r_hi  = int'(box.box_bottom) + int'(box.margin_rows) + 3;
			p.col = COORD_W'($urandom_range(clamp_coord(c_hi), clamp_coord(c_lo)));
			p.row = COORD_W'($urandom_range(clamp_coord(r_hi), clamp_coord(r_lo)));
		end
		return p;
	endfunction

	function automatic slra_cfg_t random_box();
		slra_cfg_t c;
		case ($urandom_range(9))
			0: begin
				c.box_left    = COORD_W'($urandom);
				c.box_top     = COORD_W'($urandom);
				c.box_right   = COORD_W'($urandom);
				c.box_bottom  = COORD_W'($urandom);
				c.margin_cols = COORD_W'($urandom);
				c.margin_rows = COORD_W'($urandom);
			end
			1: begin
				// corners of the register range
				c.box_left    = $urandom_range(1) ? '1 : '0;
				c.box_top     = $urandom_range(1) ? '1 : '0;
				c.box_right   = $urandom_range(1) ? '1 : '0;
				c.box_bottom  = $urandom_range(1) ? '1 : '0;
				c.margin_cols = $urandom_range(1) ? '1 : '0;
				c.margin_rows = $urandom_range(1) ? '1 : '0;
			end
			2: begin
				// inverted box
				c.box_left    = COORD_W'($urandom_range(60, 20));
				c.box_right   = COORD_W'($urandom_range(19, 0));
				c.box_top     = COORD_W'($urandom_range(60, 20));
				c.box_bottom  = COORD_W'($urandom_range(19, 0));
				c.margin_cols = $urandom_range(3) ? COORD_W'($urandom_range(8)) : '1;
				c.margin_rows = $urandom_range(3) ? COORD_W'($urandom_range(8)) : '1;
			end
			default: begin
				c.box_left    = COORD_W'($urandom_range(30));
				c.box_right   = c.box_left + COORD_W'($urandom_range(24));
				c.box_top     = COORD_W'($urandom_range(30));
				c.box_bottom  = c.box_top + COORD_W'($urandom_range(24));
				c.margin_cols = COORD_W'($urandom_range(6));
				c.margin_rows = COORD_W'($urandom_range(6));
			end
		endcase
		return c;
	endfunction

	// whole frames, the box re-programmed before about a third of them
	task automatic random_frames(int n_items);
		int     sent;
		int     len;
		pixel_t p;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(2) == 0)
				program_box(random_box(), 1'b0);
			len = ($urandom_range(7) == 0) ? $urandom_range(200, 60) : $urandom_range(40, 1);
			for (int k = 0; k < len; k++) begin
				p = random_pixel(k == len - 1);
				send_pixel(p, 1'b0, NO_WANT);
			end
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	slra_cfg_t dir_boxes [1:4] = '{
		'{12'd10,   12'd10,   12'd20,   12'd20,   12'd3,    12'd3},
		'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
		'{12'd0,    12'd0,    12'd4095, 12'd4095, 12'd0,    12'd0},
		'{12'd30,   12'd30,   12'd10,   12'd10,   12'd4095, 12'd4095}
	};

	dir_row_t dir_rows [24] = '{
		// reset box: nothing can be in the ring
		'{KEEP_BOX, '{8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    1'b1}, 1'b1,
			'{8'd0,   8'd0, 1'b1, 1'b1}},
		'{KEEP_BOX, '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b1}, 1'b1,
			'{8'd255, 8'd0, 1'b1, 1'b1}},
		'{KEEP_BOX, '{8'd255, 8'd0,   8'd0,   12'd0,    12'd4095, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX, '{8'd0,   8'd255, 8'd0,   12'd4095, 12'd0,    1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX, '{8'd0,   8'd0,   8'd255, 12'd1,    12'd1,    1'b0}, 1'b0, NO_WANT},
		// last code of the linear segment, then first of the power segment
		'{KEEP_BOX, '{8'd10,  8'd10,  8'd10,  12'd2,    12'd2,    1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX, '{8'd11,  8'd11,  8'd11,  12'd3,    12'd3,    1'b1}, 1'b0, NO_WANT},
		// small box, walk the ring edges
		'{BOX_SMALL, '{8'h12, 8'h34, 8'h56, 12'd10, 12'd15, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h9a, 8'hbc, 8'hde, 12'd15, 12'd15, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'hf0, 8'h0f, 8'h80, 12'd7,  12'd15, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h01, 8'h7f, 8'hfe, 12'd6,  12'd15, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h40, 8'hc0, 8'h20, 12'd22, 12'd7,  1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h55, 8'haa, 8'h33, 12'd23, 12'd15, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h77, 8'h88, 8'h99, 12'd15, 12'd22, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'hc3, 8'h3c, 8'h5a, 12'd15, 12'd23, 1'b1}, 1'b0, NO_WANT},
		// everything at max: every pixel lands in the ring
		'{BOX_FULL_MAX, '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b0}, 1'b1,
			'{8'd255, 8'd0, 1'b0, 1'b0}},
		'{KEEP_BOX,     '{8'd255, 8'd255, 8'd255, 12'd0,    12'd0,    1'b0}, 1'b1,
			'{8'd255, 8'd0, 1'b0, 1'b0}},
		'{KEEP_BOX,     '{8'd0,   8'd0,   8'd0,   12'd2048, 12'd2048, 1'b1}, 1'b0, NO_WANT},
		// full-frame box: only row 0 and column 0 are ring
		'{BOX_FRAME, '{8'h10, 8'h20, 8'h30, 12'd0,    12'd100, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h40, 8'h50, 8'h60, 12'd4095, 12'd100, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'h70, 8'h80, 8'h90, 12'd100,  12'd100, 1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,  '{8'ha0, 8'hb0, 8'hc0, 12'd100,  12'd0,   1'b1}, 1'b0, NO_WANT},
		// inverted box with full margins
		'{BOX_INVERTED, '{8'hff, 8'h00, 8'h7f, 12'd5,    12'd5,    1'b0}, 1'b0, NO_WANT},
		'{KEEP_BOX,     '{8'h00, 8'hff, 8'h80, 12'd3000, 12'd3000, 1'b1}, 1'b0, NO_WANT}
	};

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		build_srgb_lin();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// phase 1: sparse sink
		src_idle  = 28;
		sink_idle = 84;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].box_sel != KEEP_BOX)
				program_box(dir_boxes[dir_rows[i].box_sel], dir_rows[i].box_sel == BOX_SMALL);
			send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
		end
		random_frames(ITEMS_PER_PHASE - $size(dir_rows));

		// phase 2: sparse source
		settle();
		src_idle  = 84;
		sink_idle = 28;
		random_frames(ITEMS_PER_PHASE);

		// phase 3: full rate, opening with a long sink hold-off that backs
		// the pipe up into s_tready
		settle();
		src_idle  = 0;
		sink_idle = 0;
		hold_req  = 1'b1;
		random_frames(ITEMS_PER_PHASE);

		settle();
		$display("Ran %0d pixels in %0d frames (%0d with an empty ring), %0d ring pixels summed.",
			n_pixels, n_frames, n_empty, n_ring_px);
		$display("Checked %0d results over 3 pacing phases and %0d sink hold-off, %0d mismatches.",
			n_checked, n_holds, n_errors);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("srgb_luminance_ring_average_unit test passed");
		end else begin
			$display("srgb_luminance_ring_average_unit test failed");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// sink side: random tready, or one long hold counted here
	// ------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				n_holds++;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker: each transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tdata[15:8], m_tuser[0], m_tlast};
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected result luma %0d avg %0d empty %0b done %0b",
						$realtime, got.luma, got.ring_average, got.ring_empty, got.frame_done);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got.luma !== want.luma || got.ring_average !== want.ring_average
					|| got.ring_empty !== want.ring_empty
					|| got.frame_done !== want.frame_done) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS) begin
						$display("%0t: result %0d mismatch (expected/actual):",
							$realtime, n_checked);
						$display("  luma %0d/%0d avg %0d/%0d empty %0b/%0b done %0b/%0b",
							want.luma, got.luma,
							want.ring_average, got.ring_average,
							want.ring_empty, got.ring_empty,
							want.frame_done, got.frame_done);
					end
				end
			end
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
				idle_cycles, pending_results.size());
			$display("srgb_luminance_ring_average_unit test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
